// ===== rtl/core/mexp_pkg.sv =====
package mexp_pkg;

    // Width of the base, result and configuration data ports
    localparam int DATA_BITS = 64;

    // Configuration register map
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT = 2'd1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic init;          // latch base, acc = 1, load exponent copy
        logic clear_acc;     // force acc to zero
        logic load_reduce;   // start base mod n on the square unit
        logic load_square;   // start acc*sq and sq*sq side by side
        logic step;          // advance both serial multipliers one bit
        logic commit_reduce; // take reduced base as the square
        logic commit_bit;    // take square product, acc product if the bit is set, shift exponent right
    } mexp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic e_zero;        // no exponent bits left
        logic n_zero;        // modulus is zero
    } mexp_status_t;

endpackage

// ===== rtl/core/modular_exponentiation.sv =====
// Modular exponentiation engine: each base transferred in is raised to the
// programmed exponent modulo the programmed modulus, right-to-left square and
// multiply over the low OPERAND_BITS bits of every operand. Pulse start while
// busy is low to transfer a base; busy then stays high until the result comes
// out on power_result together with a one-cycle done strobe. The result stays
// on power_result until the next base is transferred, but done marks it for
// that single cycle only and the receiver cannot stall it, so capture it on
// done. When the exponent is zero the result is 1; else when the modulus is
// zero the result is 0; otherwise two bit-serial modular multipliers do the
// work, each taking one multiplier bit per cycle plus a load and a commit:
// the first pass reduces the base modulo n, then each exponent bit up to the
// highest set one runs the square and the conditional multiply side by side.
// Program modulus (index 0, reset 1) and exponent (index 1, reset 0) only
// while busy is low; writes to other indexes are dropped and bits above
// OPERAND_BITS ignored.
module modular_exponentiation #(
    parameter int OPERAND_BITS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [mexp_pkg::DATA_BITS-1:0]       base_value,
    output logic                                 done,
    output logic [mexp_pkg::DATA_BITS-1:0]       power_result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mexp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mexp_pkg::DATA_BITS-1:0]       cfg_data
);

    import mexp_pkg::*;

    logic [OPERAND_BITS-1:0] modulus_reg;
    logic [OPERAND_BITS-1:0] exponent_reg;
    logic [OPERAND_BITS-1:0] acc;
    mexp_cmd_t               cmd;
    mexp_status_t            status;

    // Configuration writes are always accepted: cfg_ready is tied high
    assign cfg_ready = 1'b1;

    // Hold the register file; keep only the operand bits of each write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= OPERAND_BITS'(1);
            exponent_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODULUS:
                begin
                    modulus_reg <= cfg_data[OPERAND_BITS-1:0];
                end
                REG_EXPONENT:
                begin
                    exponent_reg <= cfg_data[OPERAND_BITS-1:0];
                end
                default:
                begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // Sequencer: reduce the base, then one square/multiply pass per exponent bit
    mexp_ctrl #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Operand registers, exponent shifter and the two serial multipliers
    mexp_datapath #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_datapath (
        .clk      (clk),
        .base_in  (base_value[OPERAND_BITS-1:0]),
        .modulus  (modulus_reg),
        .exponent (exponent_reg),
        .cmd      (cmd),
        .status   (status),
        .acc      (acc)
    );

    // The accumulator is registered and stable while done is high
    assign power_result = DATA_BITS'(acc);

endmodule

// ===== rtl/core/mexp_mulmod.sv =====
module mexp_mulmod #(
    parameter int OPERAND_BITS = 64
) (
    input  logic                    clk,
    input  logic                    load,
    input  logic                    step,
    input  logic [OPERAND_BITS-1:0] a_in,
    input  logic [OPERAND_BITS-1:0] b_in,
    input  logic [OPERAND_BITS-1:0] n,
    output logic [OPERAND_BITS-1:0] r
);

    localparam int TW = OPERAND_BITS + 2;

    logic [OPERAND_BITS-1:0] a_reg;
    logic [OPERAND_BITS-1:0] b_reg;
    logic [OPERAND_BITS-1:0] r_reg;
    logic [OPERAND_BITS-1:0] r_next;
    logic [TW-1:0]           t;
    logic [TW-1:0]           n1;
    logic [TW-1:0]           n2;
    logic [TW:0]             d1;
    logic [TW:0]             d2;

    // Horner step: r = 2r + bit*a, then drop n or 2n (sum stays below 3n)
    always_comb
    begin
        n1 = {2'b00, n};
        n2 = {1'b0, n, 1'b0};
        t  = {1'b0, r_reg, 1'b0} + (b_reg[OPERAND_BITS-1] ? {2'b00, a_reg} : '0);
        d1 = {1'b0, t} - {1'b0, n1};
        d2 = {1'b0, t} - {1'b0, n2};
        if (!d2[TW])
        begin
            r_next = d2[OPERAND_BITS-1:0];
        end
        else if (!d1[TW])
        begin
            r_next = d1[OPERAND_BITS-1:0];
        end
        else
        begin
            r_next = t[OPERAND_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_reg <= a_in;
            b_reg <= b_in;
            r_reg <= '0;
        end
        else if (step)
        begin
            b_reg <= {b_reg[OPERAND_BITS-2:0], 1'b0};
            r_reg <= r_next;
        end
    end

    assign r = r_reg;

endmodule

// ===== rtl/core/mexp_datapath.sv =====
module mexp_datapath #(
    parameter int OPERAND_BITS = 64
) (
    input  logic                     clk,
    input  mexp_pkg::mexp_cmd_t      cmd,
    input  logic [OPERAND_BITS-1:0]  base_in,
    input  logic [OPERAND_BITS-1:0]  modulus,
    input  logic [OPERAND_BITS-1:0]  exponent,
    output mexp_pkg::mexp_status_t   status,
    output logic [OPERAND_BITS-1:0]  acc
);

    import mexp_pkg::*;

    logic [OPERAND_BITS-1:0] acc_reg;
    logic [OPERAND_BITS-1:0] sq_reg;
    logic [OPERAND_BITS-1:0] e_reg;
    logic [OPERAND_BITS-1:0] one_red;
    logic [OPERAND_BITS-1:0] sq_a;
    logic [OPERAND_BITS-1:0] acc_prod;
    logic [OPERAND_BITS-1:0] sq_prod;
    logic                    sq_load;

    // 1 mod n: zero when n is one
    assign one_red = {{(OPERAND_BITS-1){1'b0}}, (modulus != OPERAND_BITS'(1))};
    assign sq_a    = cmd.load_reduce ? one_red : sq_reg;
    assign sq_load = cmd.load_reduce | cmd.load_square;

    mexp_mulmod #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_acc_mul (
        .clk  (clk),
        .load (cmd.load_square),
        .step (cmd.step),
        .a_in (sq_reg),
        .b_in (acc_reg),
        .n    (modulus),
        .r    (acc_prod)
    );

    mexp_mulmod #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_sq_mul (
        .clk  (clk),
        .load (sq_load),
        .step (cmd.step),
        .a_in (sq_a),
        .b_in (sq_reg),
        .n    (modulus),
        .r    (sq_prod)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            acc_reg <= OPERAND_BITS'(1);
            sq_reg  <= base_in;
            e_reg   <= exponent;
        end
        else
        begin
            if (cmd.clear_acc)
            begin
                acc_reg <= '0;
            end
            if (cmd.commit_reduce)
            begin
                sq_reg <= sq_prod;
            end
            if (cmd.commit_bit)
            begin
                if (e_reg[0])
                begin
                    acc_reg <= acc_prod;
                end
                sq_reg <= sq_prod;
                e_reg  <= {1'b0, e_reg[OPERAND_BITS-1:1]};
            end
        end
    end

    assign status.e_zero = (e_reg == '0);
    assign status.n_zero = (modulus == '0);
    assign acc           = acc_reg;

endmodule

// ===== rtl/core/mexp_ctrl.sv =====
module mexp_ctrl #(
    parameter int OPERAND_BITS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  mexp_pkg::mexp_status_t status,
    output mexp_pkg::mexp_cmd_t    cmd,
    output logic                   busy,
    output logic                   done
);

    import mexp_pkg::*;

    localparam int CNT_BITS = $clog2(OPERAND_BITS);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_PREP       = 3'd1;
    localparam logic [2:0] S_RED_RUN    = 3'd2;
    localparam logic [2:0] S_RED_COMMIT = 3'd3;
    localparam logic [2:0] S_LOOP       = 3'd4;
    localparam logic [2:0] S_BIT_RUN    = 3'd5;
    localparam logic [2:0] S_BIT_COMMIT = 3'd6;
    localparam logic [2:0] S_FINISH     = 3'd7;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;
    logic                cnt_last;

    assign cnt_last = (cnt_reg == CNT_BITS'(OPERAND_BITS - 1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.init   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (status.e_zero)
                begin
                    state_next = S_FINISH;
                end
                else if (status.n_zero)
                begin
                    cmd.clear_acc = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    cmd.load_reduce = 1'b1;
                    cnt_next        = '0;
                    state_next      = S_RED_RUN;
                end
            end
            S_RED_RUN:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    state_next = S_RED_COMMIT;
                end
            end
            S_RED_COMMIT:
            begin
                cmd.commit_reduce = 1'b1;
                state_next        = S_LOOP;
            end
            S_LOOP:
            begin
                if (status.e_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.load_square = 1'b1;
                    cnt_next        = '0;
                    state_next      = S_BIT_RUN;
                end
            end
            S_BIT_RUN:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    state_next = S_BIT_COMMIT;
                end
            end
            S_BIT_COMMIT:
            begin
                cmd.commit_bit = 1'b1;
                state_next     = S_LOOP;
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_FINISH);

endmodule

// ===== rtl/core/mexp_checker.sv =====
module mexp_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // A transfer in always makes the engine busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
    else $error("start transfer did not raise busy");

    // Results appear only while an item is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
    else $error("done strobe while idle");

    // Each result is a single-cycle strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
    else $error("done held longer than one cycle");

    // Busy drops only right after the result strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
    else $error("busy dropped without a result");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

// ===== tb/sv/tb_modular_exponentiation.sv =====
module tb_modular_exponentiation;

    import mexp_pkg::*;

    typedef logic [DATA_BITS-1:0] word_t;

    localparam int OPERAND_BITS = 64;
    localparam word_t OPERAND_MASK = {DATA_BITS{1'b1}} >> (DATA_BITS - OPERAND_BITS);

    // Indexes past the register map: the block must drop writes to them
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

    // Largest prime below 2^64, used as a realistic modulus
    localparam word_t PRIME_64 = 64'hFFFF_FFFF_FFFF_FFC5;

    // Random part of the stimulus
    localparam int RANDOM_BASES = 120;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   start;
    logic   busy;
    word_t  base_value;
    logic   done;
    word_t  power_result;
    logic   cfg_valid;
    logic   cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    word_t  cfg_data;

    // Shadow copy of the block's configuration, updated on every register transfer
    word_t  modulus_shadow = 64'd1;
    word_t  exponent_shadow = 64'd0;

    word_t  base_queue[$];       // bases waiting for the driver
    word_t  expected_powers[$];  // predicted results, oldest first

    int     error_count = 0;
    logic   base_taken = 1'b0;   // the base on the port was transferred at the last rising edge

    // Driver pacing
    int     burst_left;
    int     gap_left = 0;
    logic   drain_hold = 1'b0;

    word_t  oldest_power;

    modular_exponentiation #(
        .OPERAND_BITS (OPERAND_BITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .base_value   (base_value),
        .done         (done),
        .power_result (power_result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic word_t random_word();
        return {$urandom, $urandom};
    endfunction

    // Product of two words reduced modulo n, n nonzero; the double-width product
    // cannot overflow, so reducing after the multiply equals reducing the operands first
    function automatic word_t mod_multiply(input word_t a, input word_t b, input word_t n);
        logic [2*DATA_BITS-1:0] product;
        product = {{DATA_BITS{1'b0}}, a} * {{DATA_BITS{1'b0}}, b};
        product = product % {{DATA_BITS{1'b0}}, n};
        return product[DATA_BITS-1:0];
    endfunction

    // Right-to-left square and multiply over the shadow configuration
    function automatic word_t predict_power(input word_t base);
        word_t n;
        word_t e;
        word_t square;
        word_t acc;
        n = modulus_shadow & OPERAND_MASK;
        e = exponent_shadow & OPERAND_MASK;
        square = base & OPERAND_MASK;
        acc = 64'd1;
        // a zero modulus leaves nothing to reduce by: the result is zero
        if (e != 0 && n == 0)
            return '0;
        while (e != 0)
        begin
            if (e[0])
                acc = mod_multiply(acc, square, n);
            square = mod_multiply(square, square, n);
            e = e >> 1;
        end
        // a zero exponent leaves the one unreduced, even for modulus one
        return acc & OPERAND_MASK;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: ERROR: %s", $time, what);
        error_count++;
    endtask

    // Block until no base is pending, queued or in flight and the block is idle
    task automatic wait_idle();
        do
            @(posedge clk);
        while (!(base_queue.size() == 0 && !start && expected_powers.size() == 0 && !busy));
    endtask

    // One register transfer, with a short random hold-off before raising valid
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index, input word_t data);
        repeat ($urandom_range(0, 2)) @(negedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_index <= CFG_INDEX_BITS'($urandom);
        cfg_data <= random_word();
    endtask

    // Reprogram both registers once the block has drained, in random order,
    // now and then slipping in a write to an unmapped index
    task automatic load_config(input word_t modulus_val, input word_t exponent_val);
        wait_idle();
        if ($urandom_range(0, 1))
        begin
            write_reg(REG_MODULUS, modulus_val);
            write_reg(REG_EXPONENT, exponent_val);
        end
        else
        begin
            write_reg(REG_EXPONENT, exponent_val);
            write_reg(REG_MODULUS, modulus_val);
        end
        if ($urandom_range(0, 4) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, random_word());
    endtask

    // Driver: launch queued bases at the falling edge, in bursts with gaps.
    // Hold start and the base until the transfer happens.
    always @(negedge clk)
    begin
        if (rst_n && !(start && !base_taken))
        begin
            if (drain_hold && expected_powers.size() == 0)
                drain_hold = 1'b0;
            if (gap_left != 0 || drain_hold || base_queue.size() == 0)
            begin
                if (gap_left != 0)
                    gap_left--;
                start <= 1'b0;
                base_value <= random_word();
            end
            else
            begin
                start <= 1'b1;
                base_value <= base_queue.pop_front();
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 8);
                    // gaps short and long, so the next start lands early, late
                    // or well after the block has gone idle
                    case ($urandom_range(0, 5))
                        0:       gap_left = 0;
                        1:       gap_left = $urandom_range(100, 1500);
                        default: gap_left = $urandom_range(1, 12);
                    endcase
                    // sometimes wait until every result is back before going on
                    drain_hold = ($urandom_range(0, 9) == 0);
                end
            end
        end
    end

    // Monitor: check results, track register transfers and predict each
    // transferred base, all at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_powers.size() == 0)
                    report_mismatch($sformatf("result %h with nothing expected", power_result));
                else
                begin
                    oldest_power = expected_powers.pop_front();
                    if (power_result !== oldest_power)
                        report_mismatch($sformatf("power_result %h, expected %h",
                                                  power_result, oldest_power));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MODULUS:  modulus_shadow = cfg_data & OPERAND_MASK;
                    REG_EXPONENT: exponent_shadow = cfg_data & OPERAND_MASK;
                    default:      ;
                endcase
            end
            if (start && !busy)
                expected_powers.push_back(predict_power(base_value));
            base_taken <= start && !busy;
        end
    end

    // Stimulus: directed cases, then random phases of configuration and bases
    initial
    begin
        word_t modulus_val;
        word_t exponent_val;
        word_t base;
        int    phase_bases;
        int    random_count;

        rst_n = 1'b0;
        start = 1'b0;
        base_value = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MODULUS;
        cfg_data = '0;
        burst_left = $urandom_range(1, 8);
        random_count = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset values: modulus one, exponent zero, so every result is one
        base_queue.push_back('0);
        base_queue.push_back('1);

        // Exponent zero with modulus zero still gives one
        load_config('0, '0);
        base_queue.push_back(random_word());

        // Modulus zero with a nonzero exponent gives zero
        load_config('0, 64'd5);
        base_queue.push_back(random_word());

        // Modulus one with the longest exponent gives zero
        load_config(64'd1, '1);
        base_queue.push_back(random_word());

        // Widest modulus and exponent; the all-ones base equals the modulus
        load_config('1, '1);
        base_queue.push_back('0);
        base_queue.push_back(64'd1);
        base_queue.push_back('1);
        base_queue.push_back('1 - 64'd1);

        // Small modulus: bases below, at and above it
        load_config(64'd13, 64'd3);
        base_queue.push_back('0);
        base_queue.push_back(64'd1);
        base_queue.push_back(64'd12);
        base_queue.push_back(64'd13);
        base_queue.push_back(64'd14);
        base_queue.push_back('1);

        // Prime modulus with the usual public exponent
        load_config(PRIME_64, 64'd65537);
        base_queue.push_back(64'd2);
        base_queue.push_back(random_word());

        // Writes to unmapped indexes must leave the configuration alone
        wait_idle();
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, random_word());
        base_queue.push_back(random_word());
        base_queue.push_back(random_word());

        // Power-of-two modulus, squaring
        load_config(64'h8000_0000_0000_0000, 64'd2);
        base_queue.push_back(64'd3);
        base_queue.push_back('1);

        // Random phases; most exponents are short to keep each base fast
        while (random_count < RANDOM_BASES)
        begin
            case ($urandom_range(0, 9))
                0:       modulus_val = word_t'($urandom_range(0, 1));
                1:       modulus_val = word_t'($urandom_range(2, 255));
                2:       modulus_val = word_t'(1) << $urandom_range(1, 63);
                3:       modulus_val = '1;
                4:       modulus_val = random_word() | 64'd1;
                default: modulus_val = random_word();
            endcase
            case ($urandom_range(0, 9))
                0:       exponent_val = '0;
                1:       exponent_val = random_word();
                2:       exponent_val = word_t'($urandom_range(1, 3));
                default: exponent_val = random_word() >> $urandom_range(48, 63);
            endcase
            load_config(modulus_val, exponent_val);

            phase_bases = $urandom_range(4, 12);
            repeat (phase_bases)
            begin
                case ($urandom_range(0, 11))
                    0:       base = '0;
                    1:       base = '1;
                    2:       base = modulus_val - 64'd1;
                    3:       base = modulus_val;
                    4:       base = modulus_val + 64'd1;
                    5:       base = word_t'($urandom_range(0, 255));
                    default: base = random_word();
                endcase
                base_queue.push_back(base);
            end
            random_count += phase_bases;
        end

        // Drain, then keep watching the block so that anything stray shows
        wait_idle();
        repeat (20) @(posedge clk);
        if (expected_powers.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_powers.size()));
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: well above the slowest legal run with full-length exponents
    initial
    begin
        #60_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mexp_pkg.sv
rtl/core/mexp_mulmod.sv
rtl/core/mexp_datapath.sv
rtl/core/mexp_ctrl.sv
rtl/core/modular_exponentiation.sv
rtl/core/mexp_checker.sv
tb/sv/tb_modular_exponentiation.sv
